// File: src/spq_pkg.sv
// Shared types, constants and helper functions for the strict-priority packet queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package spq_pkg;

	localparam int FIFO_DEPTH  = 64;
	localparam int NUM_CLASSES = 4;
	localparam int CLS_W       = $clog2(NUM_CLASSES);
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W      = $clog2(NUM_CLASSES * FIFO_DEPTH);
	localparam int BYTES_W     = 20;
	localparam int TOTAL_W     = 22;
	localparam int SIZE_W      = 14;
	localparam int TAG_W       = 16;
	localparam int QUANT_W     = 16;
	localparam int ACC_W       = QUANT_W + 1;
	localparam int DIV_IDX_W   = $clog2(ACC_W);
	localparam int ENTRY_W     = TAG_W + SIZE_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [BYTES_W-1:0] BYTES_MAX     = {BYTES_W{1'b1}};
	localparam logic [QUANT_W-1:0] QUANT_RESET   = 16'd1500;
	localparam logic [SIZE_W-1:0]  DUMMY_RESET   = 14'd1500;

	localparam logic [2:0] CLS_BULK = 3'd0;
	localparam logic [2:0] CLS_LOW  = 3'd1;
	localparam logic [2:0] CLS_MID  = 3'd2;
	localparam logic [2:0] CLS_HIGH = 3'd3;
	localparam logic [2:0] CLS_IDLE = 3'd4;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_SVC  = 2'd1;
	localparam logic [1:0] CMD_DOOR = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [1:0] KIND_CTRL  = 2'd0;
	localparam logic [1:0] KIND_NDP   = 2'd1;
	localparam logic [1:0] KIND_BULK  = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DUMMY   = 1'b1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [1:0]        pkt_kind;
		logic              trimmed;
		logic              retransmitted;
		logic [SIZE_W-1:0] pkt_size;
		logic [TAG_W-1:0]  pkt_tag;
		logic              bulk_waiting;
	} in_item_t;

	typedef struct packed {
		logic               send_valid;
		logic [TAG_W-1:0]   send_tag;
		logic [SIZE_W-1:0]  send_size;
		logic [1:0]         send_class;
		logic               bulk_pull;
		logic               push_notice;
		logic [2:0]         serving_class;
		logic [TOTAL_W-1:0] total_bytes;
		logic               dropped;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic div_step;
		logic fin;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [CLS_W-1:0] classify(input logic [1:0] kind, input logic hdr,
		input logic retx);
		logic [2:0] c;
		unique case (kind)
			KIND_CTRL:  c = CLS_HIGH;
			KIND_NDP:   c = hdr ? CLS_HIGH : (retx ? CLS_MID : CLS_LOW);
			KIND_BULK:  c = CLS_BULK;
			KIND_OTHER: c = CLS_LOW;
			default:    c = CLS_LOW;
		endcase
		return c[CLS_W-1:0];
	endfunction

endpackage

// File: src/spq_in_if.sv
// Input channel interface of the packet queue: valid, ready and one input item.
// Depends on spq_pkg for the item type.
interface spq_in_if;
	logic              valid;
	logic              ready;
	spq_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/spq_out_if.sv
// Result channel interface of the packet queue: valid, ready and one result item.
// Depends on spq_pkg for the item type.
interface spq_out_if;
	logic               valid;
	logic               ready;
	spq_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/strict_priority_packet_queue_unit.sv
// Top level of the four-class strict-priority egress packet queue.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl and spq_dpath.
//
// The block takes one item at a time on req and returns exactly one result item on rsp
// for every accepted item. An enqueue, a doorbell, a reserved command, or a service
// completion that sends nothing goes from acceptance through the update state to the
// result-load state, where the result register is loaded, and then back to idle. A
// service completion that sends a low, mid or high packet also passes through a divide
// state, because the new sent-byte remainder modulo the quantum is worked out by a
// restoring divider that retires one of 17 dividend bits per cycle. The entry memory
// is read at acceptance with a registered read port, so the entry is ready for the
// update state. A finished result sits in an output register, so the next item is
// accepted while the previous result waits on rsp; if a result is still held when the
// following one is ready, the block holds that item until the output register frees
// up. The two configuration registers (push quantum, dummy entry size) are written
// through cfg_we, cfg_idx and cfg_data and should be written only while no item is in
// flight. There is no clearing pass after reset: the entry memory is read on every
// acceptance, but only an entry from a slot that was written before is used.
module strict_priority_packet_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	spq_in_if.sink                         req,
	spq_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spq_pkg::CFG_DATA_W-1:0] cfg_data
);
	spq_pkg::ctl_cmd_t ctl_cmd;
	spq_pkg::dp_stat_t dp_stat;

	// The controller sequences accept, update, divide and result load.
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	// The datapath holds all queue state and the result register.
	spq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.in_data   (req.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

`ifndef SYNTH
	// Only one item is in work at a time, so ready drops right after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input accepted twice in a row");

	// A bulk service only requests a pull and never sends a packet.
	a_pull_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.bulk_pull |-> !rsp.data.send_valid)
		else $error("bulk pull with a sent packet");

	// A sent packet never comes from the bulk class.
	a_send_not_bulk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.send_valid |->
		rsp.data.send_class != spq_pkg::CLS_BULK[1:0])
		else $error("packet sent from bulk class");
`endif
endmodule

// File: src/spq_ctrl.sv
// Sequencing state machine of the packet queue.
// Depends on spq_pkg; drives the datapath through ctl_cmd_t and watches dp_stat_t.
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spq_pkg::dp_stat_t stat,
	output spq_pkg::ctl_cmd_t cmd
);
	spq_pkg::state_t state_q, state_nxt;
	logic out_free;

	assign out_free = !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: if (in_valid) state_nxt = spq_pkg::ST_EXEC;
			spq_pkg::ST_EXEC: state_nxt = stat.need_div ? spq_pkg::ST_DIV : spq_pkg::ST_FIN;
			spq_pkg::ST_DIV:  if (stat.div_last) state_nxt = spq_pkg::ST_FIN;
			spq_pkg::ST_FIN:  if (out_free) state_nxt = spq_pkg::ST_IDLE;
			default:          state_nxt = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			spq_pkg::ST_EXEC: cmd.exec = 1'b1;
			spq_pkg::ST_DIV:  cmd.div_step = 1'b1;
			spq_pkg::ST_FIN:  cmd.fin = out_free;
			default: ;
		endcase
	end
endmodule

// File: src/spq_dpath.sv
// Datapath of the packet queue: entry memory, pointers, byte counts, remainder divider
// and the result register. Depends on spq_pkg; steered by spq_ctrl.
module spq_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::ctl_cmd_t                 cmd,
	output spq_pkg::dp_stat_t                 stat,
	input  spq_pkg::in_item_t                 in_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output spq_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [spq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [spq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int N = spq_pkg::NUM_CLASSES;

	logic [spq_pkg::ENTRY_W-1:0] mem [spq_pkg::NUM_CLASSES * spq_pkg::FIFO_DEPTH];
	logic [spq_pkg::ENTRY_W-1:0] rd_data_s1;

	spq_pkg::in_item_t           item_q;
	logic [spq_pkg::PTR_W-1:0]   head_q [N];
	logic [spq_pkg::PTR_W-1:0]   tail_q [N];
	logic [spq_pkg::CNT_W-1:0]   cnt_q [N];
	logic [spq_pkg::BYTES_W-1:0] bytes_q [N];
	logic [2:0]                  serving_q;
	logic [spq_pkg::QUANT_W-1:0] rem_q;
	logic [spq_pkg::QUANT_W-1:0] quant_q;
	logic [spq_pkg::SIZE_W-1:0]  dummy_q;

	logic                        sv_q, pull_q, notice_q, drop_q, pick_q, svc_q;
	logic [spq_pkg::TAG_W-1:0]   stag_q;
	logic [spq_pkg::SIZE_W-1:0]  ssize_q;
	logic [1:0]                  scls_q;
	logic [spq_pkg::QUANT_W-1:0] div_r_q;
	logic [spq_pkg::ACC_W-1:0]   div_a_q;
	logic [spq_pkg::DIV_IDX_W-1:0] div_i_q;
	logic                        out_valid_q;
	spq_pkg::out_item_t          out_q;

	logic [spq_pkg::CLS_W-1:0]   srv_cls, add_cls;
	logic [spq_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
	logic                        add, full, svc_ok, svc_pop;
	logic [spq_pkg::SIZE_W-1:0]  add_size, pop_size;
	logic [spq_pkg::TAG_W-1:0]   add_tag, pop_tag;
	logic [spq_pkg::BYTES_W:0]   add_sum;
	logic [spq_pkg::ACC_W-1:0]   acc, q_eff, r_sh;
	logic [spq_pkg::TOTAL_W-1:0] total;
	logic                        any;
	logic [2:0]                  best, srv_nxt;

	assign srv_cls  = serving_q[spq_pkg::CLS_W-1:0];
	assign rd_addr  = spq_pkg::ADDR_W'(srv_cls * spq_pkg::FIFO_DEPTH) + spq_pkg::ADDR_W'(head_q[srv_cls]);
	assign add      = (item_q.cmd == spq_pkg::CMD_ENQ) ||
	                  (item_q.cmd == spq_pkg::CMD_DOOR && item_q.bulk_waiting);
	assign add_cls  = (item_q.cmd == spq_pkg::CMD_ENQ) ?
	                  spq_pkg::classify(item_q.pkt_kind, item_q.trimmed, item_q.retransmitted) :
	                  spq_pkg::CLS_BULK[spq_pkg::CLS_W-1:0];
	assign add_size = (item_q.cmd == spq_pkg::CMD_ENQ) ? item_q.pkt_size : dummy_q;
	assign add_tag  = (item_q.cmd == spq_pkg::CMD_ENQ) ? item_q.pkt_tag : '0;
	assign wr_addr  = spq_pkg::ADDR_W'(add_cls * spq_pkg::FIFO_DEPTH) + spq_pkg::ADDR_W'(tail_q[add_cls]);
	assign full     = cnt_q[add_cls] == spq_pkg::CNT_W'(spq_pkg::FIFO_DEPTH);
	assign add_sum  = {1'b0, bytes_q[add_cls]} + (spq_pkg::BYTES_W + 1)'(add_size);
	assign svc_ok   = item_q.cmd == spq_pkg::CMD_SVC && !serving_q[2] && cnt_q[srv_cls] != '0;
	assign svc_pop  = svc_ok && serving_q != spq_pkg::CLS_BULK;
	assign pop_tag  = rd_data_s1[spq_pkg::ENTRY_W-1:spq_pkg::SIZE_W];
	assign pop_size = rd_data_s1[spq_pkg::SIZE_W-1:0];
	assign acc      = {1'b0, rem_q} + spq_pkg::ACC_W'(pop_size);
	assign q_eff    = (quant_q == '0) ? spq_pkg::ACC_W'(1) : {1'b0, quant_q};
	assign r_sh     = {div_r_q, div_a_q[div_i_q]};

	// Sum of the class byte counts and the highest class that still holds bytes.
	always_comb begin
		total = '0;
		any   = 1'b0;
		best  = spq_pkg::CLS_IDLE;
		for (int c = 0; c < N; c++) begin
			total = total + spq_pkg::TOTAL_W'(bytes_q[c]);
			if (bytes_q[c] != '0) begin
				any  = 1'b1;
				best = 3'(c);
			end
		end
	end

	always_comb begin
		srv_nxt = serving_q;
		if (pick_q && any) srv_nxt = best;
		if (svc_q) srv_nxt = any ? best : spq_pkg::CLS_IDLE;
	end

	assign stat.need_div = svc_pop;
	assign stat.div_last = div_i_q == '0;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q     <= in_data;
			rd_data_s1 <= mem[rd_addr];
		end
		if (cmd.exec && add && !full) mem[wr_addr] <= {add_tag, add_size};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < N; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				cnt_q[c]   <= '0;
				bytes_q[c] <= '0;
			end
			serving_q   <= spq_pkg::CLS_IDLE;
			rem_q       <= '0;
			quant_q     <= spq_pkg::QUANT_RESET;
			dummy_q     <= spq_pkg::DUMMY_RESET;
			sv_q        <= 1'b0;
			pull_q      <= 1'b0;
			notice_q    <= 1'b0;
			drop_q      <= 1'b0;
			pick_q      <= 1'b0;
			svc_q       <= 1'b0;
			stag_q      <= '0;
			ssize_q     <= '0;
			scls_q      <= '0;
			div_r_q     <= '0;
			div_a_q     <= '0;
			div_i_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == spq_pkg::REG_QUANTUM) quant_q <= cfg_data[spq_pkg::QUANT_W-1:0];
				else dummy_q <= cfg_data[spq_pkg::SIZE_W-1:0];
			end
			if (cmd.exec) begin
				sv_q     <= svc_pop;
				pull_q   <= svc_ok && !svc_pop;
				notice_q <= svc_pop && acc >= q_eff;
				drop_q   <= add && full;
				pick_q   <= add && !full && total == '0;
				svc_q    <= item_q.cmd == spq_pkg::CMD_SVC;
				stag_q   <= svc_pop ? pop_tag : '0;
				ssize_q  <= svc_pop ? pop_size : '0;
				scls_q   <= svc_pop ? srv_cls : '0;
				if (add && !full) begin
					tail_q[add_cls]  <= (tail_q[add_cls] == spq_pkg::PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ?
					                    '0 : tail_q[add_cls] + 1'b1;
					cnt_q[add_cls]   <= cnt_q[add_cls] + 1'b1;
					bytes_q[add_cls] <= add_sum[spq_pkg::BYTES_W] ? spq_pkg::BYTES_MAX :
					                    add_sum[spq_pkg::BYTES_W-1:0];
				end
				if (item_q.cmd == spq_pkg::CMD_DOOR && !item_q.bulk_waiting) begin
					if (cnt_q[0] != '0) begin
						tail_q[0] <= (tail_q[0] == '0) ? spq_pkg::PTR_W'(spq_pkg::FIFO_DEPTH - 1) :
						             tail_q[0] - 1'b1;
						cnt_q[0]  <= cnt_q[0] - 1'b1;
					end
					bytes_q[0] <= '0;
				end
				if (svc_pop) begin
					head_q[srv_cls]  <= (head_q[srv_cls] == spq_pkg::PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ?
					                    '0 : head_q[srv_cls] + 1'b1;
					cnt_q[srv_cls]   <= cnt_q[srv_cls] - 1'b1;
					bytes_q[srv_cls] <= (bytes_q[srv_cls] > spq_pkg::BYTES_W'(pop_size)) ?
					                    bytes_q[srv_cls] - spq_pkg::BYTES_W'(pop_size) : '0;
					div_a_q <= acc;
					div_r_q <= '0;
					div_i_q <= spq_pkg::DIV_IDX_W'(spq_pkg::ACC_W - 1);
				end
			end
			// Restoring remainder: one dividend bit per cycle, MSB first.
			if (cmd.div_step) begin
				if (r_sh >= q_eff) div_r_q <= spq_pkg::QUANT_W'(r_sh - q_eff);
				else div_r_q <= r_sh[spq_pkg::QUANT_W-1:0];
				if (div_i_q == '0) begin
					rem_q <= (r_sh >= q_eff) ? spq_pkg::QUANT_W'(r_sh - q_eff) :
					         r_sh[spq_pkg::QUANT_W-1:0];
				end else begin
					div_i_q <= div_i_q - 1'b1;
				end
			end
			if (cmd.fin) begin
				serving_q   <= srv_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.send_valid    <= sv_q;
			out_q.send_tag      <= stag_q;
			out_q.send_size     <= ssize_q;
			out_q.send_class    <= scls_q;
			out_q.bulk_pull     <= pull_q;
			out_q.push_notice   <= notice_q;
			out_q.serving_class <= srv_nxt;
			out_q.total_bytes   <= total;
			out_q.dropped       <= drop_q;
		end
	end
endmodule

// File: test/strict_priority_packet_queue_unit_tb.sv
// Self-checking testbench for the four-class strict-priority packet queue.
// Depends on spq_pkg, spq_in_if, spq_out_if and strict_priority_packet_queue_unit.
module strict_priority_packet_queue_unit_tb;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int N_RANDOM = 1080;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [spq_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [spq_pkg::CFG_DATA_W-1:0] cfg_data;

	spq_in_if req ();
	spq_out_if rsp ();

	strict_priority_packet_queue_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// The predictor keeps its own copy of the queue: per-class rings of {tag, size},
	// pointers, byte counts, the class in service and the sent-byte remainder.
	logic [spq_pkg::ENTRY_W-1:0] ring_mem [spq_pkg::NUM_CLASSES][spq_pkg::FIFO_DEPTH];
	int unsigned ring_head [spq_pkg::NUM_CLASSES];
	int unsigned ring_tail [spq_pkg::NUM_CLASSES];
	int unsigned ring_fill [spq_pkg::NUM_CLASSES];
	int unsigned class_bytes [spq_pkg::NUM_CLASSES];
	int unsigned serving_now;
	int unsigned sent_rem;
	int unsigned quantum_cfg;
	int unsigned dummy_cfg;

	spq_pkg::in_item_t pending_items[$];
	spq_pkg::out_item_t expected_results[$];
	int error_count;
	bit stimulus_done;
	bit drive_enable;
	bit in_taken;

	function automatic int unsigned queued_bytes();
		int unsigned t;
		t = 0;
		for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) t += class_bytes[c];
		return t;
	endfunction

	function automatic void pick_highest();
		for (int c = spq_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
			if (class_bytes[c] > 0) begin
				serving_now = c;
				return;
			end
		end
	endfunction

	function automatic bit append_entry(int unsigned cls, logic [spq_pkg::TAG_W-1:0] tag,
		int unsigned size);
		bit was_empty;
		int unsigned sum;
		was_empty = (queued_bytes() == 0);
		if (ring_fill[cls] >= spq_pkg::FIFO_DEPTH) return 1'b0;
		ring_mem[cls][ring_tail[cls]] = {tag, size[spq_pkg::SIZE_W-1:0]};
		ring_tail[cls] = (ring_tail[cls] + 1) % spq_pkg::FIFO_DEPTH;
		ring_fill[cls]++;
		sum = class_bytes[cls] + size;
		class_bytes[cls] = (sum > spq_pkg::BYTES_MAX) ? spq_pkg::BYTES_MAX : sum;
		if (was_empty) pick_highest();
		return 1'b1;
	endfunction

	function automatic int unsigned class_of(logic [1:0] kind, logic hdr, logic retx);
		case (kind)
			spq_pkg::KIND_CTRL: return spq_pkg::CLS_HIGH;
			spq_pkg::KIND_NDP:  return hdr ? spq_pkg::CLS_HIGH :
			                    (retx ? spq_pkg::CLS_MID : spq_pkg::CLS_LOW);
			spq_pkg::KIND_BULK: return spq_pkg::CLS_BULK;
			default:            return spq_pkg::CLS_LOW;
		endcase
	endfunction

	// Applies one item to the predicted queue and returns the result it should produce.
	function automatic spq_pkg::out_item_t queue_step(spq_pkg::in_item_t it);
		spq_pkg::out_item_t r;
		int unsigned s, q, acc, sz;
		logic [spq_pkg::ENTRY_W-1:0] e;
		r = '0;
		if (it.cmd == spq_pkg::CMD_ENQ) begin
			if (!append_entry(class_of(it.pkt_kind, it.trimmed, it.retransmitted),
				it.pkt_tag, it.pkt_size)) r.dropped = 1'b1;
		end else if (it.cmd == spq_pkg::CMD_SVC) begin
			s = serving_now;
			if (s < spq_pkg::NUM_CLASSES && ring_fill[s] > 0) begin
				if (s == spq_pkg::CLS_BULK) begin
					r.bulk_pull = 1'b1;
				end else begin
					e = ring_mem[s][ring_head[s]];
					ring_head[s] = (ring_head[s] + 1) % spq_pkg::FIFO_DEPTH;
					ring_fill[s]--;
					q = (quantum_cfg == 0) ? 1 : quantum_cfg;
					sz = e[spq_pkg::SIZE_W-1:0];
					r.send_valid = 1'b1;
					r.send_tag = e[spq_pkg::ENTRY_W-1:spq_pkg::SIZE_W];
					r.send_size = e[spq_pkg::SIZE_W-1:0];
					r.send_class = s[1:0];
					class_bytes[s] = (class_bytes[s] > sz) ? class_bytes[s] - sz : 0;
					acc = sent_rem + sz;
					if (acc >= q) r.push_notice = 1'b1;
					sent_rem = acc % q;
				end
			end
			if (queued_bytes() > 0) pick_highest();
			else serving_now = spq_pkg::CLS_IDLE;
		end else if (it.cmd == spq_pkg::CMD_DOOR) begin
			if (it.bulk_waiting) begin
				if (!append_entry(spq_pkg::CLS_BULK, '0, dummy_cfg)) r.dropped = 1'b1;
			end else begin
				if (ring_fill[spq_pkg::CLS_BULK] > 0) begin
					ring_tail[spq_pkg::CLS_BULK] = (ring_tail[spq_pkg::CLS_BULK] +
						spq_pkg::FIFO_DEPTH - 1) % spq_pkg::FIFO_DEPTH;
					ring_fill[spq_pkg::CLS_BULK]--;
				end
				class_bytes[spq_pkg::CLS_BULK] = 0;
			end
		end
		r.serving_class = serving_now[2:0];
		r.total_bytes = spq_pkg::TOTAL_W'(queued_bytes());
		return r;
	endfunction

	function automatic spq_pkg::in_item_t make_item(logic [1:0] cmd, logic [1:0] kind,
		logic hdr, logic retx, int unsigned size, int unsigned tag, logic bw);
		spq_pkg::in_item_t it;
		it.cmd = cmd;
		it.pkt_kind = kind;
		it.trimmed = hdr;
		it.retransmitted = retx;
		it.pkt_size = spq_pkg::SIZE_W'(size);
		it.pkt_tag = spq_pkg::TAG_W'(tag);
		it.bulk_waiting = bw;
		return it;
	endfunction

	// Random item with live contents. Commands are weighted toward enqueues and
	// completions so the FIFOs both fill and drain; a bias value steers the mix.
	function automatic spq_pkg::in_item_t random_item(int unsigned enq_weight);
		int unsigned pick, size;
		logic [1:0] cmd;
		pick = $urandom_range(99);
		if (pick < enq_weight) cmd = spq_pkg::CMD_ENQ;
		else if (pick < 90) cmd = spq_pkg::CMD_SVC;
		else if (pick < 98) cmd = spq_pkg::CMD_DOOR;
		else cmd = spq_pkg::CMD_RSVD;
		// Mostly small sizes, with occasional extremes and arbitrary 14-bit values.
		case ($urandom_range(9))
			0: size = 0;
			1: size = 9216;
			2: size = $urandom_range(16383);
			default: size = $urandom_range(1600);
		endcase
		return make_item(cmd, 2'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), size, $urandom_range(65535), 1'($urandom_range(1)));
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Configuration writes happen on a falling edge while the block is idle; the
	// predictor follows once the write strobe is cleared.
	task automatic write_reg(logic [spq_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= spq_pkg::CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == spq_pkg::REG_QUANTUM) quantum_cfg = value & 16'hFFFF;
		else dummy_cfg = value & 14'h3FFF;
	endtask

	// Wait until every queued item has been accepted and every result checked, then
	// let the datapath settle before the next register write.
	task automatic wait_quiet();
		while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int unsigned count, int unsigned enq_weight);
		for (int i = 0; i < count; i++) pending_items.push_back(random_item(enq_weight));
		wait_quiet();
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		stimulus_done = 1'b0;
		drive_enable = 1'b0;
		quantum_cfg = spq_pkg::QUANT_RESET;
		dummy_cfg = spq_pkg::DUMMY_RESET;
		serving_now = spq_pkg::CLS_IDLE;
		sent_rem = 0;
		for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
			ring_head[c] = 0;
			ring_tail[c] = 0;
			ring_fill[c] = 0;
			class_bytes[c] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drive_enable = 1'b1;

		// Directed part at reset settings: a completion while idle, a zero-size enqueue
		// into an empty queue, every packet kind and flag, extreme sizes and tags, an
		// unknown command, doorbell add and remove, and completions across all classes.
		pending_items.push_back(make_item(spq_pkg::CMD_SVC, spq_pkg::KIND_CTRL, 1'b0, 1'b0,
			0, 0, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_OTHER, 1'b0, 1'b0,
			0, 16'h1234, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_CTRL, 1'b1, 1'b1,
			9216, 16'hFFFF, 1'b1));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_NDP, 1'b1, 1'b0,
			64, 16'h0001, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_NDP, 1'b0, 1'b1,
			1500, 16'h8000, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_NDP, 1'b0, 1'b0,
			16383, 16'h5555, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_ENQ, spq_pkg::KIND_BULK, 1'b0, 1'b0,
			700, 16'hAAAA, 1'b1));
		pending_items.push_back(make_item(spq_pkg::CMD_RSVD, spq_pkg::KIND_OTHER, 1'b1, 1'b1,
			16383, 16'hFFFF, 1'b1));
		pending_items.push_back(make_item(spq_pkg::CMD_DOOR, spq_pkg::KIND_CTRL, 1'b0, 1'b0,
			0, 0, 1'b1));
		pending_items.push_back(make_item(spq_pkg::CMD_DOOR, spq_pkg::KIND_OTHER, 1'b1, 1'b1,
			16383, 16'hFFFF, 1'b0));
		for (int i = 0; i < 8; i++)
			pending_items.push_back(make_item(spq_pkg::CMD_SVC, spq_pkg::KIND_CTRL, 1'b0, 1'b0,
				0, 0, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_DOOR, spq_pkg::KIND_CTRL, 1'b0, 1'b0,
			0, 0, 1'b0));
		pending_items.push_back(make_item(spq_pkg::CMD_SVC, spq_pkg::KIND_CTRL, 1'b0, 1'b0,
			0, 0, 1'b0));
		wait_quiet();

		// Quantum of one and dummy size of one: every send of a nonzero size crosses a boundary.
		write_reg(spq_pkg::REG_QUANTUM, 1);
		write_reg(spq_pkg::REG_DUMMY, 1);
		run_random(N_RANDOM / 5, 55);

		// Quantum zero behaves as one; heavy enqueue bias drives FIFOs to full and drops.
		write_reg(spq_pkg::REG_QUANTUM, 0);
		write_reg(spq_pkg::REG_DUMMY, 16383);
		run_random(N_RANDOM / 5, 85);

		// Largest quantum in a drain-heavy phase.
		write_reg(spq_pkg::REG_QUANTUM, 65535);
		write_reg(spq_pkg::REG_DUMMY, 9000);
		run_random(N_RANDOM / 5, 30);

		write_reg(spq_pkg::REG_QUANTUM, $urandom_range(65535, 1));
		write_reg(spq_pkg::REG_DUMMY, $urandom_range(16383, 1));
		run_random(N_RANDOM / 5, 50);

		write_reg(spq_pkg::REG_QUANTUM, 1500);
		write_reg(spq_pkg::REG_DUMMY, 1500);
		run_random(N_RANDOM - 4 * (N_RANDOM / 5), 50);

		stimulus_done = 1'b1;
	end

	// Remembers whether the input was accepted at the last rising edge; ready has
	// already dropped by the following falling edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 1'b0;
		else in_taken <= req.valid && req.ready;
	end

	// Sender: bursts of random length separated by random gaps. Items change on the
	// falling edge, so the rising edge always sees stable inputs.
	int unsigned burst_left;
	int unsigned gap_left;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (drive_enable) begin
			if (in_taken) begin
				// The item at the front was taken at the last rising edge.
				pending_items.delete(0);
			end
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				req.valid <= 1'b0;
			end else if (pending_items.size() != 0 && !(in_taken && burst_left == 0)) begin
				req.valid <= 1'b1;
				req.data <= pending_items[0];
				if (in_taken) burst_left <= burst_left - 1;
			end else begin
				req.valid <= 1'b0;
				if (in_taken) begin
					burst_left <= $urandom_range(12, 1);
					gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
				end
			end
		end
	end

	// The predictor runs on the acceptance edge so expectations stay in item order.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			expected_results.push_back(queue_step(req.data));
		end
	end

	// Receiver: a stall pattern of its own, with phases of no stalling at all.
	int unsigned stall_phase;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			case (stall_phase[9:8])
				2'd0: rsp.ready <= 1'b1;
				2'd1: rsp.ready <= ($urandom_range(3) != 0);
				2'd2: rsp.ready <= (stall_phase[2:0] != 3'd5);
				default: rsp.ready <= ($urandom_range(4) == 0);
			endcase
		end
	end

	// Result checker: each accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		spq_pkg::out_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %p", rsp.data);
				error_count++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (rsp.data.send_valid !== want.send_valid) begin
					$error("send_valid: expected %0d, got %0d", want.send_valid, rsp.data.send_valid);
					error_count++;
				end
				if (rsp.data.send_tag !== want.send_tag) begin
					$error("send_tag: expected %0h, got %0h", want.send_tag, rsp.data.send_tag);
					error_count++;
				end
				if (rsp.data.send_size !== want.send_size) begin
					$error("send_size: expected %0d, got %0d", want.send_size, rsp.data.send_size);
					error_count++;
				end
				if (rsp.data.send_class !== want.send_class) begin
					$error("send_class: expected %0d, got %0d", want.send_class,
						rsp.data.send_class);
					error_count++;
				end
				if (rsp.data.bulk_pull !== want.bulk_pull) begin
					$error("bulk_pull: expected %0d, got %0d", want.bulk_pull, rsp.data.bulk_pull);
					error_count++;
				end
				if (rsp.data.push_notice !== want.push_notice) begin
					$error("push_notice: expected %0d, got %0d", want.push_notice,
						rsp.data.push_notice);
					error_count++;
				end
				if (rsp.data.serving_class !== want.serving_class) begin
					$error("serving_class: expected %0d, got %0d", want.serving_class,
						rsp.data.serving_class);
					error_count++;
				end
				if (rsp.data.total_bytes !== want.total_bytes) begin
					$error("total_bytes: expected %0d, got %0d", want.total_bytes,
						rsp.data.total_bytes);
					error_count++;
				end
				if (rsp.data.dropped !== want.dropped) begin
					$error("dropped: expected %0d, got %0d", want.dropped, rsp.data.dropped);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item. Between
	// phases the idle wait is short, so a long quiet stretch means a hang.
	int unsigned quiet_cycles;

	initial begin
		error_count = 0;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (stimulus_done) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				if (expected_results.size() != 0) begin
					$error("%0d results never arrived", expected_results.size());
					error_count++;
				end
				if (error_count == 0) $display("DONE: 0 errors");
				else $display("DONE: errors detected");
				$finish;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$error("timeout with %0d results outstanding", expected_results.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
